// File: design/rast_pkg.sv
// Package for the range assign / range sum store.
// Holds widths and the command and status words shared by the controller and datapath.
package rast_pkg;

    localparam int POS_W = 11;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;

    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic wr_pos;
        logic rd_pos;
        logic step;
        logic out_load;
    } rast_cmd_t;

    typedef struct packed {
        logic in_empty;
        logic at_end;
        logic clr_done;
    } rast_status_t;

endpackage

// File: design/range_assign_range_sum_tree.sv
// Top level of the range assign / range sum store.
// Depends on rast_pkg, rast_ctrl and rast_datapath.
// After reset the block runs a clearing pass over its whole position memory and stalls input
// until it ends. An assign word walks its clipped positions and writes each one; a query word
// walks them reading each one, then passes a drain state and a finish state. Both walks are
// paced by the single write and read port of the memory, which handles one position per cycle.
// An assign word with an empty range writes nothing; a query word with an empty range skips the
// walk and returns zero. A finished sum waits in an output register, so the next word is taken
// while it is held, but a query cannot hand over its own sum until the held one has been taken.
module range_assign_range_sum_tree import rast_pkg::*; #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic [POS_W-1:0]        range_low,
    input  logic [POS_W-1:0]        range_high,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SUM_W-1:0] range_sum,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [POS_W-1:0]        used_length
);

    rast_cmd_t    cmd;
    rast_status_t st;

    assign cfg_ready = 1'b1;

    rast_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    rast_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .range_low  (range_low),
        .range_high (range_high),
        .value      (value),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_len    (used_length),
        .range_sum  (range_sum)
    );

endmodule

// File: design/rast_datapath.sv
// Datapath of the range assign / range sum store: position memory, walk counter and accumulator.
// Depends on rast_pkg for widths and the command and status words.
module rast_datapath import rast_pkg::*; #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rast_cmd_t               cmd,
    output rast_status_t            st,
    input  logic [POS_W-1:0]        range_low,
    input  logic [POS_W-1:0]        range_high,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    cfg_we,
    input  logic [POS_W-1:0]        cfg_len,
    output logic signed [SUM_W-1:0] range_sum
);

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int RESET_LEN = (MAX_POSITIONS < 1024) ? MAX_POSITIONS : 1024;

    logic [VAL_W-1:0] mem [MAX_POSITIONS];

    logic [POS_W-1:0]        len_reg;
    logic [POS_W-1:0]        len_next;
    logic [POS_W-1:0]        cur_reg;
    logic [POS_W-1:0]        end_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [AW-1:0]           clr_reg;
    logic [VAL_W-1:0]        rd_data_reg;
    logic                    rd_pend_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic [SUM_W-1:0]        sum_out_reg;
    logic [POS_W-1:0]        a_in;
    logic [POS_W-1:0]        b_in;
    logic [POS_W-1:0]        cur_m1;
    logic [AW-1:0]           addr;

    always_comb
    begin
        if (cfg_len == '0)
            len_next = POS_W'(1);
        else if ({21'd0, cfg_len} > 32'(MAX_POSITIONS))
            len_next = POS_W'(MAX_POSITIONS);
        else
            len_next = cfg_len;
    end

    always_comb
    begin
        a_in = (range_low == '0) ? POS_W'(1) : range_low;
        b_in = (range_high > len_reg) ? len_reg : range_high;
        cur_m1 = cur_reg - POS_W'(1);
        addr = AW'(cur_m1);
        st.in_empty = (a_in > b_in);
        st.at_end = (cur_reg == end_reg);
        st.clr_done = (clr_reg == AW'(MAX_POSITIONS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= POS_W'(RESET_LEN);
            clr_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= len_next;
            if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
            rd_pend_reg <= cmd.rd_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= a_in;
            end_reg <= b_in;
            val_reg <= value;
        end
        else if (cmd.step)
        begin
            cur_reg <= cur_reg + POS_W'(1);
        end
        if (cmd.load)
            acc_reg <= '0;
        else if (rd_pend_reg)
            acc_reg <= acc_reg + {{(SUM_W-VAL_W){rd_data_reg[VAL_W-1]}}, rd_data_reg};
        if (cmd.out_load)
            sum_out_reg <= acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[clr_reg] <= '0;
        else if (cmd.wr_pos)
            mem[addr] <= val_reg;
        if (cmd.rd_pos)
            rd_data_reg <= mem[addr];
    end

    assign range_sum = sum_out_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_pos || cmd.rd_pos) |-> (cur_reg != '0 && cur_reg <= len_reg))
        else $error("memory walk left the used positions");
    a_no_late_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !rd_pend_reg)
        else $error("result taken while a read was still pending");
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !(cmd.wr_pos || cmd.rd_pos || cmd.load))
        else $error("clearing pass overlapped other work");

endmodule

// File: design/rast_ctrl.sv
// Controller of the range assign / range sum store: clearing pass, range walks and result handoff.
// Depends on rast_pkg for the command and status words.
module rast_ctrl import rast_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         mode,
    output logic         out_valid,
    input  logic         out_stall,
    input  rast_status_t st,
    output rast_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ASSIGN = 6'b000100,
        S_QUERY  = 6'b001000,
        S_QDRAIN = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (mode == MODE_ASSIGN)
                    begin
                        if (!st.in_empty)
                            state_next = S_ASSIGN;
                    end
                    else
                    begin
                        state_next = st.in_empty ? S_FINISH : S_QUERY;
                    end
                end
            end
            S_ASSIGN:
            begin
                cmd.wr_pos = 1'b1;
                cmd.step = 1'b1;
                if (st.at_end)
                    state_next = S_IDLE;
            end
            S_QUERY:
            begin
                cmd.rd_pos = 1'b1;
                cmd.step = 1'b1;
                if (st.at_end)
                    state_next = S_QDRAIN;
            end
            S_QDRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sim/range_sum_checker.sv
// Watch-side checker for the range assign / range sum store: tracks the array, predicts sums.
// Depends on rast_pkg for widths and mode codes; instantiated beside the block by the top.
module range_sum_checker import rast_pkg::*; #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    mode,
    input  logic [POS_W-1:0]        range_low,
    input  logic [POS_W-1:0]        range_high,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [SUM_W-1:0] range_sum,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [POS_W-1:0]        used_length,
    output int                      backlog,
    output int                      failures
);

    logic signed [SUM_W-1:0] cell_value [1:MAX_POSITIONS];
    logic signed [SUM_W-1:0] sums_due [$];
    int span_len;

    function automatic logic signed [SUM_W-1:0] span_sum(int a, int b);
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int i = a; i <= b; i++)
            acc += cell_value[i];
        return acc;
    endfunction

    initial
    begin
        for (int i = 1; i <= MAX_POSITIONS; i++)
            cell_value[i] = '0;
        span_len = MAX_POSITIONS;
        failures = 0;
        backlog = 0;
    end

    always @(posedge clk)
    begin
        int a;
        int b;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                span_len = used_length;
                if (span_len < 1) span_len = 1;
                if (span_len > MAX_POSITIONS) span_len = MAX_POSITIONS;
            end
            if (in_valid && !in_stall)
            begin
                a = range_low;
                b = range_high;
                if (a < 1) a = 1;
                if (b > span_len) b = span_len;
                if (mode == MODE_ASSIGN)
                begin
                    for (int i = a; i <= b; i++)
                        cell_value[i] = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
                end
                else
                    sums_due.push_back(a > b ? '0 : span_sum(a, b));
            end
            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("range_sum: unexpected word, actual %0d", range_sum);
                    failures++;
                end
                else
                begin
                    if (range_sum !== sums_due[0])
                    begin
                        $error("range_sum: expected %0d, actual %0d", sums_due[0], range_sum);
                        failures++;
                    end
                    void'(sums_due.pop_front());
                end
            end
            backlog = sums_due.size();
        end
    end

endmodule

// File: sim/range_assign_range_sum_tree_tb.sv
// Testbench top for range_assign_range_sum_tree: drives directed and random words and lengths.
// Depends on rast_pkg, the block, and range_sum_checker, which predicts and compares sums.
module range_assign_range_sum_tree_tb import rast_pkg::*;;

    localparam int MAXP = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    mode = MODE_ASSIGN;
    logic [POS_W-1:0]        range_low = '0;
    logic [POS_W-1:0]        range_high = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [SUM_W-1:0] range_sum;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [POS_W-1:0]        used_length = '0;
    int backlog;
    int failures;
    int send_idle = 0;
    int recv_idle = 0;
    int cur_len = MAXP;
    logic hold_req = 1'b0;
    int cycles = 0;

    always #1 clk = ~clk;

    range_assign_range_sum_tree #(.MAX_POSITIONS(MAXP)) u_top (.*);

    range_sum_checker #(.MAX_POSITIONS(MAXP)) u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        bit held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                for (int n = 0; n < 3000; n++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_word(logic m, int lo, int hi, logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        range_low <= lo[POS_W-1:0];
        range_high <= hi[POS_W-1:0];
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_length(int len);
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (MAXP + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        used_length <= len[POS_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_len = len < 1 ? 1 : (len > MAXP ? MAXP : len);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_word();
        int lo;
        int hi;
        int r;
        r = $urandom_range(99);
        lo = $urandom_range(cur_len + 2);
        if (r < 3)
        begin
            lo = $urandom_range(3);
            hi = MAXP - $urandom_range(3);
        end
        else if (r < 8)
            hi = $urandom_range(2047);
        else if (r < 13)
            hi = lo - 1 - $urandom_range(4);
        else
            hi = lo + $urandom_range(24);
        if (hi < 0) hi = 0;
        if (hi > 2047) hi = 2047;
        if ($urandom_range(99) < 2) lo = 1024 + $urandom_range(1023);
        send_word(1'($urandom_range(1)), lo, hi, pick_value());
    endtask

    initial
    begin
        int lens [6];
        int idles [4][2];
        lens = '{1024, 0, 2047, 1, 600, 37};
        idles = '{'{0, 0}, '{77, 0}, '{0, 77}, '{9, 9}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_length(MAXP);

        send_word(MODE_ASSIGN, 1, 1024, 32'h7FFF_FFFF);
        send_word(MODE_QUERY, 0, 2047, '0);
        send_word(MODE_ASSIGN, 1, 1024, 32'h8000_0000);
        send_word(MODE_QUERY, 1, 1024, 32'hFFFF_FFFF);
        send_word(MODE_ASSIGN, 10, 500, '0);
        send_word(MODE_QUERY, 1, 1024, '0);
        send_word(MODE_QUERY, 5, 20, '0);
        send_word(MODE_ASSIGN, 1, 1, 32'hFFFF_FFFF);
        send_word(MODE_ASSIGN, 1024, 1024, 32'h1234_5678);
        send_word(MODE_QUERY, 1, 1, '0);
        send_word(MODE_QUERY, 1024, 2047, '0);
        send_word(MODE_ASSIGN, 30, 20, 32'h5555_5555);
        send_word(MODE_QUERY, 30, 20, '0);
        send_word(MODE_ASSIGN, 2047, 2047, 32'hAAAA_AAAA);
        send_word(MODE_QUERY, 1500, 2047, '0);
        send_word(MODE_ASSIGN, 0, 0, 32'h1);
        send_word(MODE_QUERY, 0, 3, '0);
        send_word(MODE_QUERY, 1, 1024, '0);

        for (int p = 0; p < 6; p++)
        begin
            set_length(lens[p]);
            for (int k = 0; k < 4; k++)
            begin
                send_idle = idles[k][0];
                recv_idle = idles[k][1];
                if (p == 1 && k == 0)
                    hold_req <= 1'b1;
                for (int n = 0; n < 40; n++)
                    random_word();
                if (k == 3 || $urandom_range(1))
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(40)) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (MAXP + 8) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
